// ===== design/packet_reorder_ring_buffer_defines.svh =====
// Assertion macros used by the checker file.
`ifndef PACKET_REORDER_RING_BUFFER_DEFINES_SVH
`define PACKET_REORDER_RING_BUFFER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define PRB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/prb_pkg.sv =====
package prb_pkg;

    // Command codes carried by an input beat
    localparam logic [2:0] CMD_CLEAR = 3'd0;
    localparam logic [2:0] CMD_PUSH  = 3'd1;
    localparam logic [2:0] CMD_FILL  = 3'd2;
    localparam logic [2:0] CMD_POP   = 3'd3;

    // Remainder unit: dividend width and step counter width
    localparam int DIV_W     = 17;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] offset;
        logic [11:0] byte_index;
        logic [7:0]  data_byte;
        logic        last_byte;
    } in_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [11:0] head_pos;
        logic [11:0] tail_pos;
        logic [11:0] filled_range;
        logic [12:0] contiguous_packets;
        logic        error_flag;
    } out_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLEAR,
        OP_PUSH,
        OP_RESTART,
        OP_FILL,
        OP_CONT,
        OP_STRAY,
        OP_BAD,
        OP_POP
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [15:0] offset;
        logic [11:0] byte_index;
        logic [7:0]  data_byte;
        logic        last_byte;
    } op_entry_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_DIV,
        F_CFG,
        F_RC,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC,
        BK_PUSH_CLR,
        BK_PUSH_WR,
        BK_RESTART_WR,
        BK_POP_WR,
        BK_WALK_RD,
        BK_WALK_CK
    } back_state_t;

endpackage

// ===== design/prb_rem.sv =====
module prb_rem #(
    parameter int CW = 13
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [prb_pkg::DIV_W-1:0] dividend,
    input  logic [CW-1:0]             divisor,
    output logic                      done,
    output logic [CW-1:0]             rem
);
    import prb_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [DIV_W-1:0]     dvd_reg, dvd_next;
    logic [CW-1:0]        rem_reg, rem_next;
    logic [CW:0]          trial;

    // One dividend bit per cycle, restoring remainder
    always_comb
    begin
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[DIV_W-1]};
        if (start)
        begin
            cnt_next = DIV_CNT_W'(DIV_W);
            dvd_next = dividend;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, divisor})
                rem_next = CW'(trial - {1'b0, divisor});
            else
                rem_next = CW'(trial);
            dvd_next  = dvd_reg << 1;
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ===== design/prb_front.sv =====
module prb_front #(
    parameter int CAPACITY = 4096,
    parameter int CW       = 13
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  prb_pkg::in_t       item,
    input  logic               cfg_we,
    input  logic [12:0]        cfg_wdata,
    input  logic               q_full,
    output logic               q_push,
    output prb_pkg::op_entry_t q_entry,
    output logic               front_busy,
    output logic [CW-1:0]      ps,
    output logic [CW-1:0]      rc
);
    import prb_pkg::*;

    front_state_t     state_reg, state_next;
    in_t              item_reg, item_next;
    logic             aligned_reg, aligned_next;
    logic [12:0]      psize_reg, psize_next;
    logic [CW-1:0]    rc_reg, rc_next;
    logic             needs_div;
    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic             div_done;
    logic [CW-1:0]    div_rem;
    op_kind_t         kind;

    // Effective packet size: zero reads as one, clamp to capacity
    always_comb
    begin
        if (psize_reg == '0)
            ps = CW'(1);
        else if (32'(psize_reg) > 32'(CAPACITY))
            ps = CW'(CAPACITY);
        else
            ps = CW'(psize_reg);
    end

    assign rc        = rc_reg;
    assign needs_div = ((item.command == CMD_PUSH) || (item.command == CMD_FILL)) &&
                       (item.byte_index == '0);

    prb_rem #(.CW(CW)) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (ps),
        .done     (div_done),
        .rem      (div_rem)
    );

    // Classify the held beat
    always_comb
    begin
        kind = OP_NOP;
        unique case (item_reg.command)
            CMD_CLEAR: kind = OP_CLEAR;
            CMD_PUSH, CMD_FILL:
            begin
                if (item_reg.byte_index == '0)
                begin
                    if (!aligned_reg)
                        kind = OP_BAD;
                    else if (item_reg.command == CMD_FILL)
                        kind = OP_FILL;
                    else if (32'(item_reg.offset) >= 32'(rc_reg))
                        kind = OP_RESTART;
                    else
                        kind = OP_PUSH;
                end
                else if (32'(item_reg.byte_index) < 32'(ps))
                    kind = OP_CONT;
                else
                    kind = OP_STRAY;
            end
            CMD_POP:   kind = OP_POP;
            default:   kind = OP_NOP;
        endcase
    end

    assign q_entry = '{kind:       kind,
                       offset:     item_reg.offset,
                       byte_index: item_reg.byte_index,
                       data_byte:  item_reg.data_byte,
                       last_byte:  item_reg.last_byte};

    // Front sequencer: take beat, check alignment, hand over; on a config write, work out the rounded size
    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        aligned_next = aligned_reg;
        psize_next   = psize_reg;
        rc_next      = rc_reg;
        div_start    = 1'b0;
        div_dividend = {1'b0, item.offset};
        q_push       = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (cfg_we)
                begin
                    psize_next = cfg_wdata;
                    state_next = F_CFG;
                end
                else if (accept)
                begin
                    item_next  = item;
                    div_start  = needs_div;
                    state_next = needs_div ? F_DIV : F_PUSH;
                end
            end
            F_DIV:
            begin
                if (div_done)
                begin
                    aligned_next = (div_rem == '0);
                    state_next   = F_PUSH;
                end
            end
            F_CFG:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(CAPACITY);
                state_next   = F_RC;
            end
            F_RC:
            begin
                if (div_done)
                begin
                    rc_next    = CW'(CAPACITY) - div_rem;
                    state_next = F_IDLE;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            psize_reg <= 13'd1;
            rc_reg    <= CW'(CAPACITY);
        end
        else
        begin
            state_reg <= state_next;
            psize_reg <= psize_next;
            rc_reg    <= rc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        aligned_reg <= aligned_next;
    end

    assign front_busy = (state_reg != F_IDLE);

endmodule

// ===== design/prb_queue.sv =====
module prb_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  prb_pkg::op_entry_t push_entry,
    output logic               full,
    input  logic               pop,
    output logic               valid,
    output prb_pkg::op_entry_t head_entry
);
    import prb_pkg::*;

    op_entry_t         slots [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg, rptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push, do_pop;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign valid      = (count_reg != '0);
    assign head_entry = slots[rptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && valid;

    // Store pushed beat
    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wptr_reg] <= push_entry;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= (32'(wptr_reg) == QDEPTH - 1) ? '0 : wptr_reg + 1'b1;
            if (do_pop)
                rptr_reg <= (32'(rptr_reg) == QDEPTH - 1) ? '0 : rptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== design/prb_back.sv =====
module prb_back #(
    parameter int CAPACITY = 4096,
    parameter int AW       = 12,
    parameter int CW       = 13
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_clear,
    input  logic [CW-1:0]      ps,
    input  logic [CW-1:0]      rc,
    input  logic               q_valid,
    input  prb_pkg::op_entry_t q_entry,
    output logic               q_pop,
    output logic               clearing,
    output logic               strobe,
    output prb_pkg::out_t      result
);
    import prb_pkg::*;

    back_state_t   state_reg, state_next;
    logic [AW-1:0] clr_ptr_reg, clr_ptr_next;
    logic          clr_silent_reg, clr_silent_next;
    op_entry_t     cur_reg, cur_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [AW-1:0] base_reg, base_next;
    logic [CW-1:0] phase_reg, phase_next;
    logic          wvalid_reg, wvalid_next;
    logic [7:0]    ob_reg, ob_next;
    logic          err_reg, err_next;
    logic [AW-1:0] walk_i_reg, walk_i_next;
    logic [CW-1:0] walk_cnt_reg, walk_cnt_next;
    logic          strobe_reg, strobe_next;
    out_t          result_reg, result_next;

    logic [7:0]    store_mem [CAPACITY];
    logic          occ_mem [CAPACITY];
    logic          store_we, occ_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wbyte;
    logic          mem_wocc;
    logic [7:0]    store_rdata_reg;
    logic          occ_rdata_reg;

    logic [31:0] h32, t32, r32, p32, o32;
    logic [31:0] filled32;
    logic [31:0] wsum, wpos32;
    logic [31:0] vhead, nhead32, ntsum, ntail32;
    logic        overrun;
    logic [31:0] fsum, fpos32;
    logic [31:0] csum, cpos32;
    logic [31:0] rhead32, rtsum, rtail32;
    logic [31:0] tinc, tnext32, ph_inc, pnext32;
    logic [31:0] pcinc, pcnext32;
    logic [31:0] wkinc, wknext32;
    logic [CW-1:0] fin_cnt;
    logic [31:0] cnt32;

    // Byte store and occupied marks, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (store_we)
            store_mem[mem_waddr] <= mem_wbyte;
        if (occ_we)
            occ_mem[mem_waddr] <= mem_wocc;
        store_rdata_reg <= store_mem[mem_raddr];
        occ_rdata_reg   <= occ_mem[mem_raddr];
    end

    // Position arithmetic, each position sum wraps once at the rounded size; the phase wraps at the packet size
    always_comb
    begin
        h32 = 32'(head_reg);
        t32 = 32'(tail_reg);
        r32 = 32'(rc);
        p32 = 32'(ps);
        o32 = 32'(cur_reg.offset);

        filled32 = (t32 <= h32) ? h32 - t32 : h32 + r32 - t32;

        wsum    = h32 + o32;
        wpos32  = (wsum >= r32) ? wsum - r32 : wsum;
        vhead   = wsum + p32;
        nhead32 = (vhead >= r32) ? vhead - r32 : vhead;
        ntsum   = nhead32 + p32;
        ntail32 = (ntsum >= r32) ? ntsum - r32 : ntsum;
        overrun = ((vhead >= r32) && (((t32 <= h32) && (t32 <= nhead32)) || (h32 < t32))) ||
                  ((h32 < t32) && (t32 <= nhead32));

        fsum   = t32 + o32;
        fpos32 = (fsum >= r32) ? fsum - r32 : fsum;

        csum   = 32'(base_reg) + 32'(cur_reg.byte_index);
        cpos32 = (csum >= r32) ? csum - r32 : csum;

        rhead32 = (p32 == r32) ? 32'd0 : p32;
        rtsum   = rhead32 + p32;
        rtail32 = (rtsum >= r32) ? rtsum - r32 : rtsum;

        tinc    = t32 + 32'd1;
        tnext32 = (tinc >= r32) ? 32'd0 : tinc;
        ph_inc  = 32'(phase_reg) + 32'd1;
        pnext32 = (ph_inc == p32) ? 32'd0 : ph_inc;

        pcinc    = 32'(clr_ptr_reg) + 32'd1;
        pcnext32 = (pcinc >= r32) ? 32'd0 : pcinc;

        wkinc    = 32'(walk_i_reg) + p32;
        wknext32 = (wkinc >= r32) ? wkinc - r32 : wkinc;

        fin_cnt = occ_rdata_reg ? walk_cnt_reg + 1'b1 : walk_cnt_reg;
        cnt32   = 32'(fin_cnt);
    end

    // Back sequencer: clear, execute, walk, report
    always_comb
    begin
        state_next      = state_reg;
        clr_ptr_next    = clr_ptr_reg;
        clr_silent_next = clr_silent_reg;
        cur_next        = cur_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        base_next       = base_reg;
        phase_next      = phase_reg;
        wvalid_next     = wvalid_reg;
        ob_next         = ob_reg;
        err_next        = err_reg;
        walk_i_next     = walk_i_reg;
        walk_cnt_next   = walk_cnt_reg;
        strobe_next     = 1'b0;
        result_next     = result_reg;
        q_pop           = 1'b0;
        store_we        = 1'b0;
        occ_we          = 1'b0;
        mem_waddr       = clr_ptr_reg;
        mem_wbyte       = 8'h00;
        mem_wocc        = 1'b0;
        mem_raddr       = walk_i_reg;

        if (cfg_clear)
        begin
            // Drop everything, sweep silently
            state_next      = BK_CLEAR;
            clr_ptr_next    = '0;
            clr_silent_next = 1'b1;
            head_next       = '0;
            tail_next       = '0;
            base_next       = '0;
            phase_next      = '0;
            wvalid_next     = 1'b0;
        end
        else
        begin
            unique case (state_reg)
                BK_CLEAR:
                begin
                    store_we     = 1'b1;
                    occ_we       = 1'b1;
                    clr_ptr_next = clr_ptr_reg + 1'b1;
                    if (clr_ptr_reg == AW'(CAPACITY - 1))
                    begin
                        if (clr_silent_reg)
                            state_next = BK_IDLE;
                        else if (cur_reg.kind == OP_RESTART)
                            state_next = BK_RESTART_WR;
                        else
                        begin
                            walk_i_next   = '0;
                            walk_cnt_next = '0;
                            state_next    = BK_WALK_RD;
                        end
                    end
                end
                BK_IDLE:
                begin
                    if (q_valid)
                    begin
                        q_pop      = 1'b1;
                        cur_next   = q_entry;
                        ob_next    = 8'h00;
                        err_next   = 1'b0;
                        state_next = BK_EXEC;
                    end
                end
                BK_EXEC:
                begin
                    walk_i_next   = tail_reg;
                    walk_cnt_next = '0;
                    state_next    = BK_WALK_RD;
                    unique case (cur_reg.kind)
                        OP_CLEAR, OP_RESTART:
                        begin
                            state_next      = BK_CLEAR;
                            clr_ptr_next    = '0;
                            clr_silent_next = 1'b0;
                            head_next       = '0;
                            tail_next       = '0;
                            base_next       = '0;
                            phase_next      = '0;
                            wvalid_next     = 1'b0;
                        end
                        OP_PUSH:
                        begin
                            wvalid_next = !cur_reg.last_byte;
                            if (wpos32 == h32)
                                state_next = BK_PUSH_WR;
                            else
                            begin
                                clr_ptr_next = head_reg;
                                state_next   = BK_PUSH_CLR;
                            end
                        end
                        OP_FILL:
                        begin
                            if (o32 < filled32)
                            begin
                                store_we    = 1'b1;
                                occ_we      = 1'b1;
                                mem_waddr   = AW'(fpos32);
                                mem_wbyte   = cur_reg.data_byte;
                                mem_wocc    = 1'b1;
                                base_next   = AW'(fpos32);
                                wvalid_next = !cur_reg.last_byte;
                            end
                            else
                            begin
                                err_next    = 1'b1;
                                wvalid_next = 1'b0;
                            end
                        end
                        OP_CONT:
                        begin
                            if (wvalid_reg)
                            begin
                                store_we  = 1'b1;
                                mem_waddr = AW'(cpos32);
                                mem_wbyte = cur_reg.data_byte;
                            end
                            else
                                err_next = 1'b1;
                            if (cur_reg.last_byte)
                                wvalid_next = 1'b0;
                        end
                        OP_STRAY:
                        begin
                            err_next = 1'b1;
                            if (cur_reg.last_byte)
                                wvalid_next = 1'b0;
                        end
                        OP_BAD:
                        begin
                            err_next    = 1'b1;
                            wvalid_next = 1'b0;
                        end
                        OP_POP:
                        begin
                            mem_raddr  = tail_reg;
                            state_next = BK_POP_WR;
                        end
                        default: state_next = BK_WALK_RD;
                    endcase
                end
                BK_PUSH_CLR:
                begin
                    // Zero the skipped bytes one a cycle
                    store_we     = 1'b1;
                    occ_we       = 1'b1;
                    clr_ptr_next = AW'(pcnext32);
                    if (pcnext32 == wpos32)
                        state_next = BK_PUSH_WR;
                end
                BK_PUSH_WR:
                begin
                    store_we      = 1'b1;
                    occ_we        = 1'b1;
                    mem_waddr     = AW'(wpos32);
                    mem_wbyte     = cur_reg.data_byte;
                    mem_wocc      = 1'b1;
                    base_next     = AW'(wpos32);
                    head_next     = AW'(nhead32);
                    walk_i_next   = tail_reg;
                    walk_cnt_next = '0;
                    if (overrun)
                    begin
                        tail_next   = AW'(ntail32);
                        phase_next  = '0;
                        walk_i_next = AW'(ntail32);
                    end
                    state_next = BK_WALK_RD;
                end
                BK_RESTART_WR:
                begin
                    store_we      = 1'b1;
                    occ_we        = 1'b1;
                    mem_waddr     = '0;
                    mem_wbyte     = cur_reg.data_byte;
                    mem_wocc      = 1'b1;
                    head_next     = AW'(rhead32);
                    tail_next     = AW'(rtail32);
                    base_next     = '0;
                    phase_next    = '0;
                    wvalid_next   = !cur_reg.last_byte;
                    walk_i_next   = AW'(rtail32);
                    walk_cnt_next = '0;
                    state_next    = BK_WALK_RD;
                end
                BK_POP_WR:
                begin
                    // Drain the byte read last cycle, then zero its place
                    ob_next       = store_rdata_reg;
                    store_we      = 1'b1;
                    occ_we        = 1'b1;
                    mem_waddr     = tail_reg;
                    tail_next     = AW'(tnext32);
                    phase_next    = CW'(pnext32);
                    err_next      = cur_reg.last_byte && (pnext32 != 32'd0);
                    walk_i_next   = AW'(tnext32);
                    walk_cnt_next = '0;
                    state_next    = BK_WALK_RD;
                end
                BK_WALK_RD:
                begin
                    mem_raddr  = walk_i_reg;
                    state_next = BK_WALK_CK;
                end
                BK_WALK_CK:
                begin
                    if (occ_rdata_reg && (wknext32 != t32))
                    begin
                        walk_cnt_next = fin_cnt;
                        walk_i_next   = AW'(wknext32);
                        state_next    = BK_WALK_RD;
                    end
                    else
                    begin
                        result_next.out_byte           = ob_reg;
                        result_next.head_pos           = h32[11:0];
                        result_next.tail_pos           = t32[11:0];
                        result_next.filled_range       = filled32[11:0];
                        result_next.contiguous_packets = cnt32[12:0];
                        result_next.error_flag         = err_reg;
                        strobe_next                    = 1'b1;
                        state_next                     = BK_IDLE;
                    end
                end
                default: state_next = BK_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_CLEAR;
            clr_ptr_reg    <= '0;
            clr_silent_reg <= 1'b1;
            head_reg       <= '0;
            tail_reg       <= '0;
            base_reg       <= '0;
            phase_reg      <= '0;
            wvalid_reg     <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_ptr_reg    <= clr_ptr_next;
            clr_silent_reg <= clr_silent_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            base_reg       <= base_next;
            phase_reg      <= phase_next;
            wvalid_reg     <= wvalid_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        ob_reg       <= ob_next;
        err_reg      <= err_next;
        walk_i_reg   <= walk_i_next;
        walk_cnt_reg <= walk_cnt_next;
        result_reg   <= result_next;
    end

    assign clearing = (state_reg == BK_CLEAR);
    assign strobe   = strobe_reg;
    assign result   = result_reg;

endmodule

// ===== design/packet_reorder_ring_buffer.sv =====
// Channel   Handshake                    Payload
// item      start in, busy out           prb_pkg::in_t   (one command beat)
// result    strobe out, one cycle        prb_pkg::out_t  (status after the beat)
// config    cfg_we in                    cfg_wdata[12:0] (packet size)
//
// A beat passes the front, which on the first byte of a push or fill also works out the
// offset alignment remainder, then the back, which executes it and walks the occupied
// slots from tail before the strobe. A push also clears any skipped bytes, and a clear
// or a restart sweeps the whole store. Reset and every config write run a clearing
// sweep with busy high. The result strobe cannot be held off.
module packet_reorder_ring_buffer #(
    parameter int CAPACITY = 4096
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  prb_pkg::in_t  item,
    output logic          strobe,
    output prb_pkg::out_t result,
    input  logic          cfg_we,
    input  logic [12:0]   cfg_wdata
);
    import prb_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic          accept;
    logic          front_busy;
    logic          back_clearing;
    logic [CW-1:0] ps;
    logic [CW-1:0] rc;
    logic          q_push, q_full, q_pop, q_valid;
    op_entry_t     q_in, q_out;

    assign busy   = front_busy || back_clearing;
    assign accept = start && !busy;

    prb_front #(.CAPACITY(CAPACITY), .CW(CW)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .item       (item),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (q_in),
        .front_busy (front_busy),
        .ps         (ps),
        .rc         (rc)
    );

    prb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .head_entry (q_out)
    );

    prb_back #(.CAPACITY(CAPACITY), .AW(AW), .CW(CW)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_clear (cfg_we),
        .ps        (ps),
        .rc        (rc),
        .q_valid   (q_valid),
        .q_entry   (q_out),
        .q_pop     (q_pop),
        .clearing  (back_clearing),
        .strobe    (strobe),
        .result    (result)
    );

endmodule

// ===== design/prb_checker.sv =====
`include "packet_reorder_ring_buffer_defines.svh"

module prb_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input prb_pkg::in_t  item,
    input logic          strobe,
    input prb_pkg::out_t result,
    input logic          cfg_we,
    input logic [12:0]   cfg_wdata
);

    // An accepted beat holds busy high in the cycle after
    `PRB_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accept not followed by busy")

    // A config write starts the clearing sweep
    `PRB_ASSERT_NEXT(a_cfg_busy, clk, rst_n, cfg_we, busy, "config write not followed by busy")

    // No two results come on adjacent cycles
    `PRB_ASSERT_NEXT(a_strobe_gap, clk, rst_n, strobe, !strobe, "results on adjacent cycles")

    // A result beat carries fully known fields
    `PRB_ASSERT_NOW(a_result_known, clk, rst_n, strobe, !$isunknown(result), "unknown result")

endmodule

bind packet_reorder_ring_buffer prb_checker u_prb_checker (.*);

// ===== tb/packet_reorder_ring_buffer_tb.sv =====
module packet_reorder_ring_buffer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import prb_pkg::*;

    localparam int CAP = 4096;
    localparam logic [2:0] CMD_STATUS = 3'd4;

    typedef struct {
        in_t  beat;
        bit   typed;
        out_t want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    in_t         item = '0;
    logic        strobe;
    out_t        result;
    logic        cfg_we = 1'b0;
    logic [12:0] cfg_wdata = '0;

    // shadow of the ring buffer
    logic [7:0]  ring_byte [CAP];
    bit          ring_occ [CAP];
    int unsigned ring_head, ring_tail, pkt_base, psize_reg;
    bit          pkt_open;

    out_t        status_q [$];
    bit          quiet;
    int          errors, beats, results, cfg_writes, err_beats;

    packet_reorder_ring_buffer #(.CAPACITY(CAP)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .strobe(strobe), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic int unsigned slot_bytes();
        int unsigned p;
        p = psize_reg;
        if (p == 0) p = 1;
        if (p > CAP) p = CAP;
        return p;
    endfunction

    function automatic void wipe_ring();
        foreach (ring_byte[i])
        begin
            ring_byte[i] = '0;
            ring_occ[i] = 1'b0;
        end
        ring_head = 0;
        ring_tail = 0;
        pkt_base = 0;
        pkt_open = 1'b0;
    endfunction

    function automatic int unsigned span_bytes(int unsigned rc);
        if (ring_tail <= ring_head) return ring_head - ring_tail;
        return ring_head + (rc - ring_tail);
    endfunction

    function automatic int unsigned run_from_tail(int unsigned ps, int unsigned rc);
        int unsigned cnt, i;
        cnt = 0;
        i = ring_tail % rc;
        do
        begin
            if (!ring_occ[i]) break;
            cnt++;
            i = (i + ps) % rc;
        end
        while (i != ring_tail % rc);
        return cnt;
    endfunction

    function automatic bit place_at_head(int unsigned off, logic [7:0] b,
                                         int unsigned ps, int unsigned rc);
        int unsigned wpos, i, vh, nh, nt;
        if (off % ps != 0) return 1'b0;
        // offset past the store restarts it
        if (off >= rc)
        begin
            wipe_ring();
            ring_byte[0] = b;
            ring_occ[0] = 1'b1;
            ring_head = ps % rc;
            ring_tail = (ring_head + ps) % rc;
            pkt_base = 0;
            return 1'b1;
        end
        wpos = (ring_head + off) % rc;
        for (i = ring_head; i != wpos; i = (i + 1) % rc)
        begin
            ring_byte[i] = '0;
            ring_occ[i] = 1'b0;
        end
        ring_byte[wpos] = b;
        ring_occ[wpos] = 1'b1;
        pkt_base = wpos;
        vh = ring_head + off + ps;
        nh = vh % rc;
        nt = (nh + ps) % rc;
        // push tail along on overrun
        if (vh >= rc && ((ring_tail <= ring_head && ring_tail <= nh) || ring_head < ring_tail))
            ring_tail = nt;
        else if (ring_head < ring_tail && ring_tail <= nh)
            ring_tail = nt;
        ring_head = nh;
        return 1'b1;
    endfunction

    function automatic bit place_in_gap(int unsigned off, logic [7:0] b,
                                        int unsigned ps, int unsigned rc);
        int unsigned pos;
        if (off % ps != 0) return 1'b0;
        if (off >= span_bytes(rc)) return 1'b0;
        pos = (ring_tail + off) % rc;
        ring_byte[pos] = b;
        ring_occ[pos] = 1'b1;
        pkt_base = pos;
        return 1'b1;
    endfunction

    // advance the shadow by one beat and return the status it reports
    function automatic out_t apply_beat(in_t x);
        int unsigned ps, rc, t;
        bit ok, err;
        out_t r;
        ps = slot_bytes();
        rc = (CAP / ps) * ps;
        err = 1'b0;
        r = '0;
        case (x.command)
            CMD_CLEAR: wipe_ring();
            CMD_PUSH, CMD_FILL:
            begin
                if (x.byte_index == 0)
                begin
                    ok = (x.command == CMD_PUSH) ? place_at_head(x.offset, x.data_byte, ps, rc)
                                                 : place_in_gap(x.offset, x.data_byte, ps, rc);
                    pkt_open = ok && !x.last_byte;
                    err = !ok;
                end
                else if (pkt_open && x.byte_index < ps)
                begin
                    ring_byte[(pkt_base + x.byte_index) % rc] = x.data_byte;
                    if (x.last_byte) pkt_open = 1'b0;
                end
                else
                begin
                    err = 1'b1;
                    if (x.last_byte) pkt_open = 1'b0;
                end
            end
            CMD_POP:
            begin
                t = ring_tail % rc;
                r.out_byte = ring_byte[t];
                ring_byte[t] = '0;
                ring_occ[t] = 1'b0;
                ring_tail = (t + 1) % rc;
                if (x.last_byte && ring_tail % ps != 0) err = 1'b1;
            end
            default: ;
        endcase
        r.head_pos = ring_head[11:0];
        r.tail_pos = ring_tail[11:0];
        r.filled_range = 12'(span_bytes(rc));
        r.contiguous_packets = 13'(run_from_tail(ps, rc));
        r.error_flag = err;
        return r;
    endfunction

    task automatic report(string field, int got, int want);
        $display("%0t mismatch on %s: got %0h, want %0h", $realtime, field, got, want);
        errors++;
    endtask

    // check each result beat against the oldest expected status
    always @(posedge clk)
    begin : status_check
        out_t w;
        if (rst_n && strobe)
        begin
            results++;
            if (status_q.size() == 0)
                report("unexpected result", 1, 0);
            else
            begin
                w = status_q.pop_front();
                if (result.out_byte !== w.out_byte) report("out_byte", result.out_byte, w.out_byte);
                if (result.head_pos !== w.head_pos) report("head_pos", result.head_pos, w.head_pos);
                if (result.tail_pos !== w.tail_pos) report("tail_pos", result.tail_pos, w.tail_pos);
                if (result.filled_range !== w.filled_range)
                    report("filled_range", result.filled_range, w.filled_range);
                if (result.contiguous_packets !== w.contiguous_packets)
                    report("contiguous_packets", result.contiguous_packets, w.contiguous_packets);
                if (result.error_flag !== w.error_flag)
                    report("error_flag", result.error_flag, w.error_flag);
            end
        end
    end

    // hold a beat until accepted; queue either the typed or the predicted status
    task automatic send_beat(in_t x, bit typed = 1'b0, out_t want = '0);
        int gap;
        out_t p;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item <= x;
        do @(posedge clk); while (busy);
        p = apply_beat(x);
        if (p.error_flag) err_beats++;
        status_q.push_back(typed ? want : p);
        beats++;
    endtask

    // drop start and hold until every status beat has come back
    task automatic drain();
        start <= 1'b0;
        while (status_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_size(logic [12:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        psize_reg = v;
        wipe_ring();
        cfg_writes++;
        repeat (2) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // one packet of push or fill beats, sometimes broken
    task automatic send_packet(logic [2:0] cmd, int unsigned off, int unsigned ps);
        int unsigned len, j;
        in_t x;
        len = (ps <= 8) ? ps : $urandom_range(1, 6);
        for (j = 0; j < len; j++)
        begin
            x = '0;
            x.command = cmd;
            x.offset = (j == 0) ? 16'(off) : 16'($urandom);
            x.byte_index = 12'(j);
            x.data_byte = 8'($urandom);
            x.last_byte = (j == len - 1);
            if (j == len - 1 && j > 0 && ps > 8) x.byte_index = 12'($urandom_range(j, ps - 1));
            if (j == len - 1 && ps < CAP && $urandom_range(0, 9) == 0)
                x.byte_index = 12'($urandom_range(ps, CAP - 1));
            send_beat(x);
        end
    endtask

    task automatic random_phase(int n);
        int sent, r, k, j, len;
        int unsigned ps, rc, off, fr;
        in_t x;
        sent = 0;
        ps = slot_bytes();
        rc = (CAP / ps) * ps;
        while (sent < n)
        begin
            if ($urandom_range(0, 39) == 0) quiet = ~quiet;
            if ($urandom_range(0, 149) == 0) drain();
            r = $urandom_range(0, 99);
            x = '0;
            if (r < 50)
            begin
                k = $urandom_range(0, 9);
                if (k < 8)
                    off = (ps >= 1024) ? 0 : $urandom_range(0, 3) * ps;
                else if (k == 8)
                    off = $urandom_range(rc, 65535);
                else
                    off = $urandom_range(0, 65535);
                send_packet(CMD_PUSH, off, ps);
                sent += (ps <= 8) ? ps : 4;
            end
            else if (r < 65)
            begin
                fr = span_bytes(rc);
                off = (fr >= ps) ? $urandom_range(0, fr / ps - 1) * ps : 0;
                if ($urandom_range(0, 7) == 0) off = $urandom_range(0, 65535);
                send_packet(CMD_FILL, off, ps);
                sent += (ps <= 8) ? ps : 4;
            end
            else if (r < 85)
            begin
                len = (ps <= 8) ? ps : $urandom_range(1, 8);
                for (j = 0; j < len; j++)
                begin
                    x = '0;
                    x.command = CMD_POP;
                    x.offset = 16'($urandom);
                    x.byte_index = 12'($urandom);
                    x.data_byte = 8'($urandom);
                    x.last_byte = (j == len - 1);
                    send_beat(x);
                end
                sent += len;
            end
            else if (r < 87)
            begin
                x.command = CMD_CLEAR;
                send_beat(x);
                sent++;
            end
            else
            begin
                // noise: status, unused codes and stray bytes
                x = in_t'(40'({$urandom, $urandom}));
                if (x.command == CMD_CLEAR && $urandom_range(0, 3) != 0) x.command = CMD_STATUS;
                send_beat(x);
                sent++;
            end
        end
    endtask

    dir_row_t dir_tab [14] = '{
        '{'{CMD_STATUS, 16'd0, 12'd0, 8'h00, 1'b0}, 1, '{8'h00, 12'd0, 12'd0, 12'd0, 13'd0, 1'b0}},
        '{'{CMD_PUSH, 16'd0, 12'd0, 8'hA5, 1'b1}, 1, '{8'h00, 12'd1, 12'd0, 12'd1, 13'd1, 1'b0}},
        '{'{CMD_PUSH, 16'd0, 12'd5, 8'h11, 1'b1}, 1, '{8'h00, 12'd1, 12'd0, 12'd1, 13'd1, 1'b1}},
        '{'{CMD_FILL, 16'd0, 12'd0, 8'h3C, 1'b1}, 0, '0},
        '{'{CMD_FILL, 16'd1, 12'd0, 8'h77, 1'b1}, 1, '{8'h00, 12'd1, 12'd0, 12'd1, 13'd1, 1'b1}},
        '{'{CMD_POP, 16'd0, 12'd0, 8'h00, 1'b1}, 1, '{8'h3C, 12'd1, 12'd1, 12'd0, 13'd0, 1'b0}},
        '{'{CMD_POP, 16'hFFFF, 12'hFFF, 8'hFF, 1'b1}, 0, '0},
        '{'{CMD_PUSH, 16'hFFFF, 12'd0, 8'hFF, 1'b0}, 0, '0},
        '{'{CMD_PUSH, 16'hFFFF, 12'd1, 8'h00, 1'b1}, 0, '0},
        '{'{CMD_PUSH, 16'd2, 12'd0, 8'h5A, 1'b1}, 0, '0},
        '{'{3'd7, 16'hFFFF, 12'hFFF, 8'hFF, 1'b1}, 0, '0},
        '{'{3'd5, 16'h1234, 12'h321, 8'h42, 1'b0}, 0, '0},
        '{'{CMD_CLEAR, 16'hFFFF, 12'hFFF, 8'hFF, 1'b1}, 1, '{8'h00, 12'd0, 12'd0, 12'd0, 13'd0, 1'b0}},
        '{'{CMD_PUSH, 16'd0, 12'hFFF, 8'hFF, 1'b1}, 1, '{8'h00, 12'd0, 12'd0, 12'd0, 13'd0, 1'b1}}
    };

    logic [12:0] size_plan [10] = '{13'd4096, 13'd0, 13'd8191, 13'd3, 13'd7,
                                    13'd16, 13'd100, 13'd1000, 13'd5, 13'd1};

    initial
    begin
        psize_reg = 1;
        wipe_ring();
        quiet = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);

        // directed rows
        foreach (dir_tab[i])
            send_beat(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].want);
        random_phase(150);

        // random beats across packet sizes
        foreach (size_plan[i])
        begin
            write_size(size_plan[i]);
            random_phase(158);
        end

        drain();
        if (status_q.size() != 0)
        begin
            $display("%0d expected results never arrived", status_q.size());
            errors++;
        end
        $display("%0d beats over %0d packet sizes, %0d results checked, %0d error beats",
                 beats, cfg_writes + 1, results, err_beats);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2s;
        $display("FAIL");
        $finish;
    end

endmodule
